>>> design/address_lease_pool_server_top_defines.svh
// assertion macros shared by the lease pool server
`ifndef ADDRESS_LEASE_POOL_SERVER_TOP_DEFINES_SVH
`define ADDRESS_LEASE_POOL_SERVER_TOP_DEFINES_SVH

// implication checked at every clock edge outside reset
`define ALPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication checked outside reset
`define ALPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/alps_pkg.sv
`default_nettype none
package alps_pkg;
	localparam int PoolSizeDefault = 256;

	localparam logic [1:0] ST_FREE     = 2'd0;
	localparam logic [1:0] ST_PENDING  = 2'd1;
	localparam logic [1:0] ST_OCCUPIED = 2'd2;
	localparam logic [1:0] ST_EXPIRED  = 2'd3;

	localparam logic [1:0] KIND_DISCOVER = 2'd0;
	localparam logic [1:0] KIND_REQUEST  = 2'd1;

	localparam logic [1:0] REPLY_OFFER = 2'd0;
	localparam logic [1:0] REPLY_ACK   = 2'd1;
	localparam logic [1:0] REPLY_NAK   = 2'd2;

	localparam logic [2:0] REG_POOL_IN_USE   = 3'd0;
	localparam logic [2:0] REG_LEASE_DEFAULT = 3'd1;
	localparam logic [2:0] REG_LEASE_MAX     = 3'd2;
	localparam logic [2:0] REG_LEASE_MIN     = 3'd3;
	localparam logic [2:0] REG_SERVER_ID     = 3'd4;

	typedef enum logic [1:0] {
		OP_DROP,
		OP_DISCOVER,
		OP_REQ_SELF,
		OP_REQ_OTHER
	} op_t;

	// classified message word passed from front to back
	typedef struct packed {
		op_t         op;
		logic [31:0] msg_time;
		logic [15:0] sender;
		logic [15:0] asked_address;
		logic [32:0] lease;
	} msg_t;
endpackage
`default_nettype wire

>>> design/address_lease_pool_server_top.sv
// Lease pool server. A message is taken when start is high and busy is low;
// its reply, if any, shows on the result ports with result_valid high for one
// cycle and cannot be held off. The front register holds the message after it
// is classified and its lease clamped; the per-entry cells then age the pool
// and the priority encoder picks, and the result register presents the reply.
// The pool needs no clearing after reset.
`default_nettype none
`include "address_lease_pool_server_top_defines.svh"
module address_lease_pool_server_top
	import alps_pkg::*;
#(
	parameter int POOL_SIZE = PoolSizeDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] msg_time,
	input  wire logic [15:0] sender_id,
	input  wire logic        to_broadcast,
	input  wire logic [15:0] receiver_id,
	input  wire logic [15:0] asked_address,
	input  wire logic [31:0] asked_expiry,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             result_valid,
	output logic [1:0]       reply_kind,
	output logic [15:0]      client_id,
	output logic [15:0]      reply_address,
	output logic [32:0]      lease_end
);
	logic [8:0]  pool_in_use_q;
	logic [31:0] lease_default_q, lease_max_q, lease_min_q;
	logic [15:0] server_id_q;
	logic        accept, valid_s1, done;
	logic [1:0]  inflight_q;
	msg_t        word_s1;

	assign accept    = start && !busy;
	assign busy      = inflight_q != 2'd0;
	assign cfg_ready = 1'b1;

	// items in flight until the back stage finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 2'd0;
		end else if (accept) begin
			inflight_q <= 2'd1;
		end else if (done) begin
			inflight_q <= 2'd0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_in_use_q   <= 9'd256;
			lease_default_q <= 32'd3600;
			lease_max_q     <= 32'd10000;
			lease_min_q     <= 32'd60;
			server_id_q     <= 16'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POOL_IN_USE:   pool_in_use_q   <= cfg_data[8:0];
				REG_LEASE_DEFAULT: lease_default_q <= cfg_data;
				REG_LEASE_MAX:     lease_max_q     <= cfg_data;
				REG_LEASE_MIN:     lease_min_q     <= cfg_data;
				REG_SERVER_ID:     server_id_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	alps_front u_front (
		.clk, .arst_n, .in_valid(accept), .req_type, .msg_time, .sender_id,
		.to_broadcast, .receiver_id, .asked_address, .asked_expiry,
		.lease_default(lease_default_q), .lease_max(lease_max_q),
		.lease_min(lease_min_q), .server_id(server_id_q),
		.word_s1, .valid_s1
	);

	alps_back #(.POOL_SIZE(POOL_SIZE)) u_back (
		.clk, .arst_n, .word_valid(valid_s1), .word(word_s1),
		.pool_in_use(pool_in_use_q), .done, .res_valid(result_valid),
		.reply_kind, .client_id, .reply_address, .lease_end
	);

	`ALPS_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	`ALPS_ASSERT_NEXT(a_front_follows, clk, arst_n, accept, valid_s1)
	`ALPS_ASSERT_IMP(a_nak_zero, clk, arst_n, result_valid && reply_kind == REPLY_NAK,
		lease_end == 33'd0)
endmodule
`default_nettype wire

>>> design/alps_front.sv
`default_nettype none
module alps_front
	import alps_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] msg_time,
	input  wire logic [15:0] sender_id,
	input  wire logic        to_broadcast,
	input  wire logic [15:0] receiver_id,
	input  wire logic [15:0] asked_address,
	input  wire logic [31:0] asked_expiry,
	input  wire logic [31:0] lease_default,
	input  wire logic [31:0] lease_max,
	input  wire logic [31:0] lease_min,
	input  wire logic [15:0] server_id,
	output msg_t             word_s1,
	output logic             valid_s1
);
	logic [32:0] lo, hi, dflt, e0, e1, e2;
	op_t         op;

	// lease clamp: default, raise to min, lower to max
	always_comb begin
		lo   = {1'b0, msg_time} + {1'b0, lease_min};
		hi   = {1'b0, msg_time} + {1'b0, lease_max};
		dflt = {1'b0, msg_time} + {1'b0, lease_default};
		e0   = (asked_expiry == 32'd0) ? dflt : {1'b0, asked_expiry};
		e1   = (e0 < lo) ? lo : e0;
		e2   = (e1 > hi) ? hi : e1;
	end

	// classify by kind, broadcast and receiver
	always_comb begin
		op = OP_DROP;
		if (req_type == KIND_DISCOVER && to_broadcast) begin
			op = OP_DISCOVER;
		end else if (req_type == KIND_REQUEST && !to_broadcast) begin
			op = (receiver_id == server_id) ? OP_REQ_SELF : OP_REQ_OTHER;
		end
	end

	// front register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			word_s1 <= '{op: op, msg_time: msg_time, sender: sender_id,
				asked_address: asked_address, lease: e2};
		end
	end
endmodule
`default_nettype wire

>>> design/alps_back.sv
`default_nettype none
module alps_back
	import alps_pkg::*;
#(
	parameter int POOL_SIZE = PoolSizeDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        word_valid,
	input  msg_t             word,
	input  wire logic [8:0]  pool_in_use,
	output logic             done,
	output logic             res_valid,
	output logic [1:0]       reply_kind,
	output logic [15:0]      client_id,
	output logic [15:0]      reply_address,
	output logic [32:0]      lease_end
);
	localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

	logic [1:0]  status_q [POOL_SIZE];
	logic [15:0] holder_q [POOL_SIZE];
	logic        held_q   [POOL_SIZE];
	logic [32:0] expiry_q [POOL_SIZE];

	logic [POOL_SIZE-1:0] act, expd, hit, fre, exd, pend_mine;
	logic [1:0]  nstat [POOL_SIZE];
	logic [32:0] nexp  [POOL_SIZE];
	logic [IW-1:0] pick;
	logic          found;
	logic [16:0]   addr_m1;
	logic          ack_ok;
	logic [IW-1:0] ack_idx;

	// per-entry aging and match cells
	always_comb begin
		for (int i = 0; i < POOL_SIZE; i++) begin
			act[i]  = (32'(i) < 32'(pool_in_use));
			expd[i] = act[i] && expiry_q[i] != 33'd0 &&
				expiry_q[i] <= {1'b0, word.msg_time};
			nstat[i] = status_q[i];
			nexp[i]  = expiry_q[i];
			if (expd[i] && status_q[i] == ST_PENDING) begin
				nstat[i] = ST_FREE;
				nexp[i]  = 33'd0;
			end else if (expd[i] && status_q[i] == ST_OCCUPIED) begin
				nstat[i] = ST_EXPIRED;
				nexp[i]  = 33'd0;
			end
			// a freed entry drops its holder too
			hit[i] = act[i] && held_q[i] && holder_q[i] == word.sender &&
				!(expd[i] && status_q[i] == ST_PENDING);
			fre[i] = act[i] && nstat[i] == ST_FREE;
			exd[i] = act[i] && nstat[i] == ST_EXPIRED;
			pend_mine[i] = hit[i] && nstat[i] == ST_PENDING;
		end
	end

	// priority encoder: own entry, else lowest free, else lowest expired
	always_comb begin
		pick  = '0;
		found = 1'b0;
		for (int i = POOL_SIZE - 1; i >= 0; i--) if (exd[i]) begin
			pick = IW'(i); found = 1'b1;
		end
		for (int i = POOL_SIZE - 1; i >= 0; i--) if (fre[i]) begin
			pick = IW'(i); found = 1'b1;
		end
		for (int i = POOL_SIZE - 1; i >= 0; i--) if (hit[i]) begin
			pick = IW'(i); found = 1'b1;
		end
	end

	// acknowledge check on the asked address
	always_comb begin
		addr_m1 = {1'b0, word.asked_address} - 17'd1;
		ack_idx = addr_m1[IW-1:0];
		ack_ok  = word.asked_address != 16'd0 &&
			{1'b0, word.asked_address} <= {8'd0, pool_in_use} &&
			32'(word.asked_address) <= 32'(POOL_SIZE) && hit[ack_idx];
	end

	// pool state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				status_q[i] <= ST_FREE;
				holder_q[i] <= 16'd0;
				held_q[i]   <= 1'b0;
				expiry_q[i] <= 33'd0;
			end
		end else if (word_valid) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				status_q[i] <= nstat[i];
				expiry_q[i] <= nexp[i];
				if (nstat[i] == ST_FREE && status_q[i] != ST_FREE) begin
					holder_q[i] <= 16'd0;
					held_q[i]   <= 1'b0;
				end
				if (word.op == OP_REQ_OTHER && pend_mine[i]) begin
					status_q[i] <= ST_FREE;
					holder_q[i] <= 16'd0;
					held_q[i]   <= 1'b0;
					expiry_q[i] <= 33'd0;
				end
			end
			if (word.op == OP_DISCOVER && found) begin
				status_q[pick] <= ST_PENDING;
				holder_q[pick] <= word.sender;
				held_q[pick]   <= 1'b1;
				expiry_q[pick] <= word.lease;
			end
			if (word.op == OP_REQ_SELF && ack_ok) begin
				status_q[ack_idx] <= ST_OCCUPIED;
				expiry_q[ack_idx] <= word.lease;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
			done      <= 1'b0;
		end else begin
			done      <= word_valid;
			res_valid <= word_valid && ((word.op == OP_DISCOVER && found) ||
				word.op == OP_REQ_SELF);
		end
	end

	always_ff @(posedge clk) begin
		if (word_valid) begin
			client_id <= word.sender;
			if (word.op == OP_DISCOVER) begin
				reply_kind    <= REPLY_OFFER;
				reply_address <= 16'(32'(pick) + 32'd1);
				lease_end     <= word.lease;
			end else begin
				reply_kind    <= ack_ok ? REPLY_ACK : REPLY_NAK;
				reply_address <= word.asked_address;
				lease_end     <= ack_ok ? word.lease : 33'd0;
			end
		end
	end
endmodule
`default_nettype wire
